### src/cia_pkg.sv
// shared types, codes and constants of the checked 64-bit arithmetic unit
package cia_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned HALF_W      = WORD_W / 2;
    localparam int unsigned DIV_STEPS   = WORD_W;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic        [1:0]        mode;
        logic signed [WORD_W-1:0] left_operand;
        logic signed [WORD_W-1:0] right_operand;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic        [1:0]        status;
    } t_out_item;

    // classified item passed from front to back
    typedef struct packed {
        t_mode              kind;
        logic               neg;
        logic [1:0]         st;
        logic [WORD_W-1:0]  val;
        logic [WORD_W-1:0]  amag;
        logic [WORD_W-1:0]  bmag;
    } t_work;

endpackage

### src/cia_front.sv
// front end: add/subtract, special-case detection and operand magnitudes
module cia_front import cia_pkg::*; (
    input  t_in_item i_item,
    output t_work    o_work
);

    logic [WORD_W-1:0] a, b, sum, dif;
    logic              a_min, b_m1;

    always_comb begin
        a      = i_item.left_operand;
        b      = i_item.right_operand;
        sum    = a + b;
        dif    = a - b;
        a_min  = (a == {1'b1, {(WORD_W-1){1'b0}}});
        b_m1   = (b == {WORD_W{1'b1}});

        o_work.kind = t_mode'(i_item.mode);
        o_work.neg  = a[WORD_W-1] ^ b[WORD_W-1];
        o_work.amag = a[WORD_W-1] ? (~a + 1'b1) : a;
        o_work.bmag = b[WORD_W-1] ? (~b + 1'b1) : b;
        o_work.val  = '0;
        o_work.st   = ST_OK;
        case (t_mode'(i_item.mode))
            MODE_ADD: begin
                o_work.val = sum;
                if (~(a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ sum[WORD_W-1])) begin
                    o_work.st = ST_OVF;
                end
            end
            MODE_SUB: begin
                o_work.val = dif;
                if ((a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ dif[WORD_W-1])) begin
                    o_work.st = ST_OVF;
                end
            end
            MODE_DIV: begin
                // zero divisor wins over the most-negative by minus-one case
                if (b == '0) begin
                    o_work.st = ST_DIVZ;
                end else if (a_min && b_m1) begin
                    o_work.st = ST_OVF;
                end
            end
            default: begin
                o_work.st = ST_OK;
            end
        endcase
    end

endmodule

### src/cia_fifo.sv
// short register queue between front and back
module cia_fifo import cia_pkg::*; #(
    parameter int unsigned Depth = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_work            r_mem [Depth];
    logic [PtrW-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0]  r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign n_wr    = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= n_wr;
            end
            if (rd_en) begin
                r_rd <= n_rd;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### src/cia_back.sv
// back end: pipelined multiplier and one-bit-per-stage divider, output register
module cia_back import cia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_work     i_q_item,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    typedef struct packed {
        t_mode             kind;
        logic              neg;
        logic [1:0]        st;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] rem;
    } t_stage;

    typedef struct packed {
        logic [WORD_W-1:0] p00;
        logic [WORD_W-1:0] p01;
        logic [WORD_W-1:0] p10;
        logic [WORD_W-1:0] p11;
    } t_mulpart;

    // one restoring division step: quotient bits shift into num
    function automatic t_stage div_step(input t_stage s);
        t_stage      r;
        logic [WORD_W:0] sh;
        logic        ge;
        r  = s;
        sh = {s.rem, s.num[WORD_W-1]};
        ge = (sh >= {1'b0, s.den});
        r.rem = ge ? WORD_W'(sh - {1'b0, s.den}) : sh[WORD_W-1:0];
        r.num = {s.num[WORD_W-2:0], ge};
        return r;
    endfunction

    t_stage            r_stg [DIV_STEPS+1];
    t_stage            n_stg [DIV_STEPS+1];
    logic              r_v   [DIV_STEPS+1];
    t_mulpart          r_m0, n_m0;
    t_out_item         r_out, n_out;
    logic              r_out_v;
    logic              adv;
    logic [WORD_W+1:0] mid;
    logic [WORD_W-1:0] lo, hi, q;

    assign adv     = !r_out_v || i_pop;
    assign o_q_pop = adv && i_q_valid;
    assign o_empty = !r_out_v;
    assign o_item  = r_out;

    always_comb begin
        n_stg[0].kind = i_q_item.kind;
        n_stg[0].neg  = i_q_item.neg;
        n_stg[0].st   = i_q_item.st;
        n_stg[0].val  = i_q_item.val;
        n_stg[0].num  = i_q_item.amag;
        n_stg[0].den  = i_q_item.bmag;
        n_stg[0].rem  = '0;
        n_m0.p00 = i_q_item.amag[HALF_W-1:0]      * i_q_item.bmag[HALF_W-1:0];
        n_m0.p01 = i_q_item.amag[HALF_W-1:0]      * i_q_item.bmag[WORD_W-1:HALF_W];
        n_m0.p10 = i_q_item.amag[WORD_W-1:HALF_W] * i_q_item.bmag[HALF_W-1:0];
        n_m0.p11 = i_q_item.amag[WORD_W-1:HALF_W] * i_q_item.bmag[WORD_W-1:HALF_W];
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
        // product recombination rides alongside the first division step
        mid = (WORD_W+2)'(r_m0.p00[WORD_W-1:HALF_W])
            + (WORD_W+2)'(r_m0.p01[HALF_W-1:0])
            + (WORD_W+2)'(r_m0.p10[HALF_W-1:0]);
        lo  = {mid[HALF_W-1:0], r_m0.p00[HALF_W-1:0]};
        hi  = r_m0.p11 + WORD_W'(r_m0.p01[WORD_W-1:HALF_W])
            + WORD_W'(r_m0.p10[WORD_W-1:HALF_W]) + WORD_W'(mid[WORD_W+1:HALF_W]);
        if (r_stg[0].kind == MODE_MUL) begin
            n_stg[1].val = r_stg[0].neg ? (~lo + 1'b1) : lo;
            if ((hi != '0) || (r_stg[0].neg ? (lo[WORD_W-1] && (lo[WORD_W-2:0] != '0))
                                            : lo[WORD_W-1])) begin
                n_stg[1].st = ST_OVF;
            end
        end
        q = r_stg[DIV_STEPS].num;
        n_out.status = r_stg[DIV_STEPS].st;
        if (r_stg[DIV_STEPS].st != ST_OK) begin
            n_out.value = '0;
        end else if (r_stg[DIV_STEPS].kind == MODE_DIV) begin
            n_out.value = r_stg[DIV_STEPS].neg ? (~q + 1'b1) : q;
        end else begin
            n_out.value = r_stg[DIV_STEPS].val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_q_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_v <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_m0  <= n_m0;
            r_out <= n_out;
        end
    end

endmodule

### src/checked_int64_arithmetic.sv
// top level of the overflow-checked signed 64-bit arithmetic unit
//
// usage: both sides look like queues. a transaction goes in at an edge with
// push high and full low; i_in_item carries mode and the two operands.
// results come out in order: while empty is low the oldest result sits on
// o_out_item, and it leaves at an edge with pop high.
// every input transaction gives exactly one result transaction.
// path: a result passes the front queue, the first back stage that forms
// the four 32x32 partial products, 64 single-bit division stages (the
// product is recombined next to the first of them), and the output
// register. add, subtract and multiply run the same stages as divide, so
// order is kept.
// throughput: one transaction per cycle while the output is not stalled,
// set by the single-bit-per-stage divider pipeline that takes a new
// dividend every cycle.
// stall: while a result waits with pop low, the whole back pipeline holds;
// the front queue fills and full rises until the receiver takes a result.
// reset: synchronous, active low; queue and pipeline empty, full low.
module checked_int64_arithmetic import cia_pkg::*; #(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_work front_work;   // classified item from the front
    t_work q_item;       // head of the front queue
    logic  q_empty;
    logic  q_pop;

    // front: sums, differences, error screening, magnitudes
    cia_front u_front (
        .i_item (i_in_item),
        .o_work (front_work)
    );

    // decouples acceptance from back-end stalls
    cia_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    // back: multiply and divide pipeline, output register
    cia_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

### src/cia_checker.sv
// port-level checks of the arithmetic unit and their bind
module cia_checker import cia_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_no_st3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.status == ST_OK || o_out_item.status == ST_OVF ||
                    o_out_item.status == ST_DIVZ))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_item.status != ST_OK |-> o_out_item.value == '0)
        else $error("nonzero value with error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("result changed while stalled");

endmodule

bind checked_int64_arithmetic cia_checker u_cia_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

### dv/tb_checked_int64_arithmetic.sv
// self-checking testbench of the overflow-checked signed 64-bit arithmetic unit
`timescale 1ns / 1ps

module tb_checked_int64_arithmetic;
    import cia_pkg::*;

    // scoreboard: predicts each result and checks the results in order
    class arith_scoreboard;
        t_out_item pending_results[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // predicted result of one input transaction
        function t_out_item compute(t_in_item it);
            t_out_item         res;
            logic signed [WORD_W-1:0] a;
            logic signed [WORD_W-1:0] b;
            logic signed [WORD_W:0]   wide_sum;
            logic signed [2*WORD_W-1:0] prod;
            a = it.left_operand;
            b = it.right_operand;
            res.value  = '0;
            res.status = ST_OK;
            case (t_mode'(it.mode))
                MODE_ADD: begin
                    wide_sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
                    if (wide_sum[WORD_W] != wide_sum[WORD_W-1]) res.status = ST_OVF;
                    else res.value = wide_sum[WORD_W-1:0];
                end
                MODE_SUB: begin
                    wide_sum = {a[WORD_W-1], a} - {b[WORD_W-1], b};
                    if (wide_sum[WORD_W] != wide_sum[WORD_W-1]) res.status = ST_OVF;
                    else res.value = wide_sum[WORD_W-1:0];
                end
                MODE_MUL: begin
                    prod = 128'(a) * 128'(b);
                    // exact product must fit: upper half all copies of the sign
                    if (prod[2*WORD_W-1:WORD_W-1] != {(WORD_W+1){prod[WORD_W-1]}})
                        res.status = ST_OVF;
                    else
                        res.value = prod[WORD_W-1:0];
                end
                default: begin
                    if (b == 0) res.status = ST_DIVZ;
                    else if (a == {1'b1, {(WORD_W-1){1'b0}}} && b == -64'sd1)
                        res.status = ST_OVF;
                    else res.value = a / b;  // truncates toward zero
                end
            endcase
            return res;
        endfunction

        function void note_input(t_in_item it);
            pending_results.push_back(compute(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: actual value %0d status %0d",
                         $time, got.value, got.status);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.value !== exp_res.value) begin
                $display("%0t value mismatch: expected %0d actual %0d",
                         $time, exp_res.value, got.value);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $display("%0t status mismatch: expected %0d actual %0d",
                         $time, exp_res.status, got.status);
                errors++;
            end
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 200000;
    localparam int     RANDOM_ITEMS = 500;
    localparam logic signed [63:0] MIN_VAL = {1'b1, 63'd0};
    localparam logic signed [63:0] MAX_VAL = {1'b0, {63{1'b1}}};

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    arith_scoreboard sb;
    longint    cycle_count = 0;
    bit        quiet_phase;   // no idling in the last part of the run

    checked_int64_arithmetic dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // global cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // monitor: sample both handshakes at the edge, before the new drive lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_input(i_in_item);
            if (pop && !empty) sb.check_result(o_out_item);
        end
    end

    // receiver: random stall bursts, none started in the quiet phase
    initial begin : receiver
        int burst;
        burst = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
                pop <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // random operand biased toward edge values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return 64'(-1);
            3: return 64'(0);
            4: return 64'($urandom_range(0, 5)) - 64'd2;
            5: return {{32{1'b0}}, 32'($urandom)};
            6: return {{33{$urandom_range(0, 1) == 1}}, 31'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // one input transaction; holds push high until accepted
    task automatic send_item(t_mode m, logic [63:0] a, logic [63:0] b);
        t_in_item it;
        it.mode          = m;
        it.left_operand  = a;
        it.right_operand = b;
        i_in_item <= it;
        push      <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // optional idle burst on the sender side
    task automatic sender_gap();
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin : main
        t_mode m;
        int    wait_cycles;
        sb          = new();
        quiet_phase = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_in_item   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and each special case
        send_item(MODE_ADD, MAX_VAL, 64'd1);          // add overflow up
        send_item(MODE_ADD, MIN_VAL, 64'(-1));        // add overflow down
        send_item(MODE_ADD, MAX_VAL, MIN_VAL);
        send_item(MODE_ADD, {64{1'b1}}, {64{1'b1}});
        send_item(MODE_SUB, MIN_VAL, 64'd1);          // sub overflow down
        send_item(MODE_SUB, MAX_VAL, 64'(-1));        // sub overflow up
        send_item(MODE_SUB, 64'd0, MIN_VAL);
        send_item(MODE_SUB, 64'(-1), MIN_VAL);
        send_item(MODE_MUL, MIN_VAL, 64'(-1));        // product overflow
        send_item(MODE_MUL, MIN_VAL, 64'd1);          // product exactly min
        send_item(MODE_MUL, 64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000);
        send_item(MODE_MUL, 64'hFFFF_FFFF_8000_0000, 64'h0000_0001_0000_0000);
        send_item(MODE_MUL, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_0000_0000);
        send_item(MODE_MUL, MAX_VAL, MAX_VAL);
        send_item(MODE_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
        send_item(MODE_DIV, 64'd7, 64'd0);            // divide by zero
        send_item(MODE_DIV, MIN_VAL, 64'd0);
        send_item(MODE_DIV, MIN_VAL, 64'(-1));        // min / -1 overflow
        send_item(MODE_DIV, 64'(-7), 64'd2);          // truncation toward zero
        send_item(MODE_DIV, 64'd7, 64'(-2));
        send_item(MODE_DIV, MIN_VAL, 64'd1);
        send_item(MODE_DIV, MAX_VAL, MIN_VAL);
        send_item(MODE_DIV, MIN_VAL, MIN_VAL);

        // random part; last fifth runs without idling
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS * 4 / 5) quiet_phase = 1'b1;
            sender_gap();
            m = t_mode'($urandom_range(0, 3));
            send_item(m, pick_operand(), pick_operand());
        end
        push <= 1'b0;

        // drain, then a short tail for stray results
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        wait_cycles = 100;
        repeat (wait_cycles) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
